### hw/rtl/bads_pkg.sv
package bads_pkg;

    // Field widths of the cell store
    localparam int SUM_W   = 28;
    localparam int CNT_W   = 20;
    localparam int WORD_W  = SUM_W + CNT_W;
    localparam int MEAN_W  = 16;
    localparam int COORD_W = 10;
    localparam int PACE_W  = 11;
    localparam int GRID_W  = 9;

    // Cell index arithmetic: quotient * grid width + quotient
    localparam int PROD_W  = COORD_W + GRID_W;
    localparam int IDX_W   = PROD_W + 1;

    // A cell count saturates here
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Shared divider: 16 quotient bits, divisor up to 20 bits
    localparam int DIV_QW  = 16;
    localparam int DIV_DW  = 20;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_PACE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V_PACE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd2;

    // Item kinds
    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MULT,
        ST_ADDR,
        ST_UPDATE,
        ST_RD_CELL,
        ST_MEAN,
        ST_EMIT
    } t_state;

    // Request into the shared divider
    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] rem_init;
        logic [DIV_QW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    // Answer from the shared divider
    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quo;
    } t_div_rsp;

endpackage

### hw/rtl/bads_ram.sv
module bads_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bads_div.sv
module bads_div
    import bads_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(DIV_QW);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_QW-1:0] r_quo;
    logic [DIV_DW-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   trial;
    logic              fits;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign trial = {r_rem, r_quo[DIV_QW-1]};
    assign fits  = trial >= {1'b0, r_den};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIV_DW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIV_DW-1:0];
            end
            r_quo <= {r_quo[DIV_QW-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### hw/rtl/block_average_downscaler_top.sv
// Block-average downscaler. Pixel transfers (kind 0) add the pixel value into the
// grid cell (pixel_y / v_pace) * grid_width + pixel_x / h_pace; read transfers
// (kind 1) return the cell's mean in 8.8 fixed point with its pixel count and an
// empty flag, then clear the cell. After reset the block sweeps the cell store
// to zero, one cell per cycle, with o_ready low. All division runs on one shared
// radix-2 divider that works out one quotient bit per step. A pixel goes through
// two divisions, one multiply, a store read and a store write (no store access
// when the cell falls outside the store); a read of a filled cell goes through a
// store read, one division and the output load; a read of an empty cell goes
// through a store read and the output load; and a pixel with a zero pace setting
// is dropped in the idle state. A read is held while the output register is still
// waiting for its transfer. Cell counts stop at 1048575; pixels past that point
// and pixels landing outside the store are dropped. A finished result waits in
// the output register while the next transfer is taken.
module block_average_downscaler_top
    import bads_pkg::*;
#(
    parameter int MAX_CELLS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [COORD_W-1:0]   i_pixel_x,
    input  logic [COORD_W-1:0]   i_pixel_y,
    input  logic [7:0]           i_pixel_value,
    input  logic [7:0]           i_read_cell,

    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_cell_index,
    output logic [MEAN_W-1:0]    o_cell_mean,
    output logic [CNT_W-1:0]     o_cell_pixels,
    output logic                 o_cell_empty,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PACE_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    // Configuration registers
    logic [PACE_W-1:0] r_h_pace;
    logic [PACE_W-1:0] r_v_pace;
    logic [GRID_W-1:0] r_grid_w;

    // Sequencer and item registers
    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_addr;
    logic [COORD_W-1:0] r_y;
    logic [7:0]         r_val;
    logic [7:0]         r_rc;
    logic [COORD_W-1:0] r_qx;
    logic [COORD_W-1:0] r_qy;
    logic [PROD_W-1:0]  r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic [MEAN_W-1:0]  r_mean;

    // Output register
    logic               r_o_valid;
    logic [7:0]         r_o_index;
    logic [MEAN_W-1:0]  r_o_mean;
    logic [CNT_W-1:0]   r_o_pixels;
    logic               r_o_empty;

    // Datapath wires
    logic               in_fire;
    logic               out_free;
    logic [IDX_W-1:0]   rc_wide;
    logic               rc_in;
    logic [IDX_W-1:0]   idx;
    logic               idx_in;
    logic [SUM_W-1:0]   rd_sum;
    logic [CNT_W-1:0]   rd_cnt;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_valid && o_ready;
    assign out_free    = !r_o_valid || i_ready;

    assign rc_wide = IDX_W'(i_read_cell);
    assign rc_in   = rc_wide < IDX_W'(MAX_CELLS);
    assign idx     = IDX_W'(r_prod) + IDX_W'(r_qx);
    assign idx_in  = idx < IDX_W'(MAX_CELLS);

    assign rd_sum = ram_rdata[WORD_W-1:CNT_W];
    assign rd_cnt = ram_rdata[CNT_W-1:0];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_pace <= PACE_W'(1);
            r_v_pace <= PACE_W'(1);
            r_grid_w <= GRID_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_H_PACE:     r_h_pace <= i_cfg_data;
                CFG_V_PACE:     r_v_pace <= i_cfg_data;
                CFG_GRID_WIDTH: r_grid_w <= i_cfg_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Next state, divider requests and store access
    always_comb begin
        n_state   = r_state;
        div_req   = '0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = r_addr;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == AW'(MAX_CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_kind == KIND_ACCUM) begin
                        if (r_h_pace != '0 && r_v_pace != '0) begin
                            div_req.start = 1'b1;
                            div_req.num   = DIV_QW'(i_pixel_x);
                            div_req.den   = DIV_DW'(r_h_pace);
                            n_state       = ST_DIV_X;
                        end
                    end else if (rc_in) begin
                        ram_raddr = rc_wide[AW-1:0];
                        n_state   = ST_RD_CELL;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_DIV_X: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_QW'(r_y);
                    div_req.den   = DIV_DW'(r_v_pace);
                    n_state       = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_rsp.done) begin
                    n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                if (idx_in) begin
                    ram_raddr = idx[AW-1:0];
                    n_state   = ST_UPDATE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_UPDATE: begin
                // Drop the pixel once the count is saturated
                if (rd_cnt != COUNT_MAX) begin
                    ram_we    = 1'b1;
                    ram_wdata = {SUM_W'(rd_sum + SUM_W'(r_val)), CNT_W'(rd_cnt + 1'b1)};
                end
                n_state = ST_IDLE;
            end
            ST_RD_CELL: begin
                // Clear the cell while a filled cell's contents go to the divider
                ram_we = 1'b1;
                if (rd_cnt == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = rd_sum[SUM_W-1:8];
                    div_req.num      = {rd_sum[7:0], 8'h00};
                    div_req.den      = rd_cnt;
                    n_state          = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (div_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Capture item fields and intermediate results
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_y    <= i_pixel_y;
                    r_val  <= i_pixel_value;
                    r_rc   <= i_read_cell;
                    r_addr <= rc_wide[AW-1:0];
                    r_cnt  <= '0;
                    r_mean <= '0;
                end
            end
            ST_DIV_X: begin
                if (div_rsp.done) begin
                    r_qx <= div_rsp.quo[COORD_W-1:0];
                end
            end
            ST_DIV_Y: begin
                if (div_rsp.done) begin
                    r_qy <= div_rsp.quo[COORD_W-1:0];
                end
            end
            ST_MULT: begin
                r_prod <= r_qy * r_grid_w;
            end
            ST_ADDR: begin
                r_addr <= idx[AW-1:0];
            end
            ST_RD_CELL: begin
                r_cnt <= rd_cnt;
            end
            ST_MEAN: begin
                if (div_rsp.done) begin
                    r_mean <= div_rsp.quo;
                end
            end
            default: ;
        endcase
    end

    // Load the output register and drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_o_index  <= r_rc;
            r_o_mean   <= r_mean;
            r_o_pixels <= r_cnt;
            r_o_empty  <= (r_cnt == '0);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_cell_index  = r_o_index;
    assign o_cell_mean   = r_o_mean;
    assign o_cell_pixels = r_o_pixels;
    assign o_cell_empty  = r_o_empty;

    // Cell store: sum in the upper bits, count in the lower bits
    bads_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared divider for both cell coordinates and the mean
    bads_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

### hw/rtl/bads_checker.sv
module bads_checker
    import bads_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [7:0]        o_cell_index,
    input logic [MEAN_W-1:0] o_cell_mean,
    input logic [CNT_W-1:0]  o_cell_pixels,
    input logic              o_cell_empty
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cell_index) && $stable(o_cell_mean)
            && $stable(o_cell_pixels) && $stable(o_cell_empty))
        else $error("stalled result changed");

    // Empty flag follows the pixel count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cell_empty == (o_cell_pixels == '0)))
        else $error("empty flag disagrees with pixel count");

    // Empty cells report a zero mean
    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cell_empty |-> o_cell_mean == '0)
        else $error("empty cell with nonzero mean");

    // A mean of 8-bit pixels never exceeds 255.0
    a_mean_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cell_mean <= 16'hFF00)
        else $error("mean above full scale");

endmodule

bind block_average_downscaler_top bads_checker u_bads_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_cell_index  (o_cell_index),
    .o_cell_mean   (o_cell_mean),
    .o_cell_pixels (o_cell_pixels),
    .o_cell_empty  (o_cell_empty)
);

### dv/block_average_downscaler_top_tb.sv
`timescale 1ns / 100ps

module block_average_downscaler_top_tb;
    import bads_pkg::*;

    localparam int NUM_CELLS     = 256;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 210;
    localparam int MAX_PRINTS    = 50;

    // Register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [7:0]         pv;
        logic [7:0]         rc;
    } grid_item_t;

    typedef struct {
        logic [7:0]        cell_idx;
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0]  pixels;
        logic              empty;
    } cell_report_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic                 i_kind        = KIND_ACCUM;
    logic [COORD_W-1:0]   i_pixel_x     = '0;
    logic [COORD_W-1:0]   i_pixel_y     = '0;
    logic [7:0]           i_pixel_value = '0;
    logic [7:0]           i_read_cell   = '0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic [7:0]           o_cell_index;
    logic [MEAN_W-1:0]    o_cell_mean;
    logic [CNT_W-1:0]     o_cell_pixels;
    logic                 o_cell_empty;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_H_PACE;
    logic [PACE_W-1:0]    i_cfg_data    = '0;

    // Mirror of the cell store and the grid registers
    logic [SUM_W-1:0]  grid_sums   [NUM_CELLS];
    logic [CNT_W-1:0]  grid_counts [NUM_CELLS];
    logic [PACE_W-1:0] h_pace_q  = 11'd1;
    logic [PACE_W-1:0] v_pace_q  = 11'd1;
    logic [GRID_W-1:0] grid_w_q  = 9'd1;

    grid_item_t   grid_items[$];
    cell_report_t pending_reports[$];
    int           items_unsent   = 0;
    int           mismatch_count = 0;
    bit           item_taken     = 1'b0;
    bit           hold_req       = 1'b0;

    block_average_downscaler_top #(
        .MAX_CELLS (NUM_CELLS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_value (i_pixel_value),
        .i_read_cell   (i_read_cell),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_index  (o_cell_index),
        .o_cell_mean   (o_cell_mean),
        .o_cell_pixels (o_cell_pixels),
        .o_cell_empty  (o_cell_empty),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        for (int i = 0; i < NUM_CELLS; i++) begin
            grid_sums[i]   = '0;
            grid_counts[i] = '0;
        end
    end

    // Grid cell that a pixel falls into; paces must be nonzero
    function automatic int unsigned cell_of(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                            logic [PACE_W-1:0] h, logic [PACE_W-1:0] v,
                                            logic [GRID_W-1:0] gw);
        int unsigned col;
        int unsigned row;
        col = 32'(x) / 32'(h);
        row = 32'(y) / 32'(v);
        return row * 32'(gw) + col;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // Bin a pixel into its cell, or read out and clear a cell
    task automatic predict_downscale(grid_item_t it);
        int unsigned     idx;
        longint unsigned scaled;
        cell_report_t    rep;
        if (it.kind == KIND_ACCUM) begin
            if (h_pace_q != 0 && v_pace_q != 0) begin
                idx = cell_of(it.px, it.py, h_pace_q, v_pace_q, grid_w_q);
                if (idx < NUM_CELLS && grid_counts[idx] != COUNT_MAX) begin
                    grid_counts[idx] = grid_counts[idx] + CNT_W'(1);
                    grid_sums[idx]   = grid_sums[idx] + SUM_W'(it.pv);
                end
            end
        end else begin
            rep.cell_idx = it.rc;
            rep.mean     = '0;
            rep.pixels   = '0;
            if (it.rc < NUM_CELLS) begin
                rep.pixels = grid_counts[it.rc];
                if (rep.pixels != 0) begin
                    scaled   = 64'(grid_sums[it.rc]) * 256;
                    rep.mean = 16'(scaled / rep.pixels);
                end
                grid_counts[it.rc] = '0;
                grid_sums[it.rc]   = '0;
            end
            rep.empty = (rep.pixels == 0);
            pending_reports.push_back(rep);
        end
    endtask

    // Track transfers on all three channels, check results, run the watchdog
    always @(posedge i_clk) begin
        grid_item_t   it;
        cell_report_t want;
        bit           moved;
        int           quiet_cycles;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_H_PACE:     h_pace_q = i_cfg_data;
                    CFG_V_PACE:     v_pace_q = i_cfg_data;
                    CFG_GRID_WIDTH: grid_w_q = i_cfg_data[GRID_W-1:0];
                    default: ;
                endcase
                moved = 1'b1;
            end
            if (i_valid && o_ready) begin
                it.kind = i_kind;
                it.px   = i_pixel_x;
                it.py   = i_pixel_y;
                it.pv   = i_pixel_value;
                it.rc   = i_read_cell;
                predict_downscale(it);
                items_unsent--;
                item_taken = 1'b1;
                moved      = 1'b1;
            end
            if (o_valid && i_ready) begin
                moved = 1'b1;
                if (pending_reports.size() == 0) begin
                    report_mismatch("result with none pending", o_cell_index, -1);
                end else begin
                    want = pending_reports.pop_front();
                    if (o_cell_index !== want.cell_idx)
                        report_mismatch("cell_index", o_cell_index, want.cell_idx);
                    if (o_cell_mean !== want.mean)
                        report_mismatch("cell_mean", o_cell_mean, want.mean);
                    if (o_cell_pixels !== want.pixels)
                        report_mismatch("cell_pixels", o_cell_pixels, want.pixels);
                    if (o_cell_empty !== want.empty)
                        report_mismatch("cell_empty", o_cell_empty, want.empty);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer queued items, hold each until its transfer, then maybe idle
    always @(negedge i_clk) begin
        grid_item_t cur;
        int         send_gap;
        bit         send_steady;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap    = 0;
            send_steady = 1'b0;
        end else if (i_valid && !item_taken) begin
            // hold the offered item
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap--;
        end else if (grid_items.size() > 0) begin
            cur = grid_items.pop_front();
            i_valid       <= 1'b1;
            i_kind        <= cur.kind;
            i_pixel_x     <= cur.px;
            i_pixel_y     <= cur.py;
            i_pixel_value <= cur.pv;
            i_read_cell   <= cur.rc;
            if ($urandom_range(0, 39) == 0)
                send_steady = !send_steady;
            send_gap = send_steady ? 0 : idle_gap();
        end else begin
            i_valid <= 1'b0;
        end
        item_taken = 1'b0;
    end

    // Accept results with random stalls and one long hold on request
    always @(negedge i_clk) begin
        int hold_left;
        int stall_left;
        bit take_steady;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_left   = 0;
            stall_left  = 0;
            take_steady = 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            i_ready <= 1'b0;
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 39) == 0)
                take_steady = !take_steady;
            if (!take_steady && $urandom_range(0, 3) == 0)
                stall_left = idle_gap();
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(int h, int v, int gw);
        write_reg(CFG_H_PACE, PACE_W'(h));
        write_reg(CFG_V_PACE, PACE_W'(v));
        write_reg(CFG_GRID_WIDTH, PACE_W'(gw));
    endtask

    function automatic grid_item_t random_item();
        grid_item_t it;
        it.kind = 1'($urandom_range(0, 1));
        it.px   = COORD_W'($urandom_range(0, 1023));
        it.py   = COORD_W'($urandom_range(0, 1023));
        it.pv   = 8'($urandom_range(0, 255));
        it.rc   = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic push_item(grid_item_t it);
        grid_items.push_back(it);
        items_unsent++;
    endtask

    task automatic push_pixel(int x, int y, int v);
        grid_item_t it;
        it      = random_item();
        it.kind = KIND_ACCUM;
        it.px   = COORD_W'(x);
        it.py   = COORD_W'(y);
        it.pv   = 8'(v);
        push_item(it);
    endtask

    task automatic push_read(int c);
        grid_item_t it;
        it      = random_item();
        it.kind = KIND_READ;
        it.rc   = 8'(c);
        push_item(it);
    endtask

    // Wait for every item and result, then let a dropped pixel finish
    task automatic drain_items();
        while (items_unsent != 0 || pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly pixels inside the image that the grid covers, reads aimed at
    // recently filled cells, and some pixels anywhere
    task automatic queue_phase(int n);
        grid_item_t  it;
        int unsigned span_x;
        int unsigned span_y;
        int unsigned rows;
        int unsigned last_cell;
        int          pick;
        span_x = (grid_w_q == 0) ? NUM_CELLS * 32'(h_pace_q) : 32'(grid_w_q) * 32'(h_pace_q);
        if (span_x == 0 || span_x > 1024)
            span_x = 1024;
        rows   = (grid_w_q == 0) ? 1024 : (NUM_CELLS + 32'(grid_w_q) - 1) / 32'(grid_w_q);
        span_y = rows * 32'(v_pace_q);
        if (span_y == 0 || span_y > 1024)
            span_y = 1024;
        last_cell = NUM_CELLS;
        repeat (n) begin
            it   = random_item();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                it.kind = KIND_ACCUM;
                it.px   = COORD_W'($urandom_range(0, span_x - 1));
                it.py   = COORD_W'($urandom_range(0, span_y - 1));
            end else if (pick < 78) begin
                it.kind = KIND_ACCUM;
            end else begin
                it.kind = KIND_READ;
                if (pick < 94 && last_cell < NUM_CELLS)
                    it.rc = 8'(last_cell);
            end
            if (it.kind == KIND_ACCUM && h_pace_q != 0 && v_pace_q != 0)
                last_cell = cell_of(it.px, it.py, h_pace_q, v_pace_q, grid_w_q);
            push_item(it);
        end
    endtask

    task automatic run_phase(int h, int v, int gw, int n);
        set_grid(h, v, gw);
        queue_phase(n);
        drain_items();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 64x64 image in 4x4 cells: extremes, rounding, drops, empty reads
        set_grid(4, 4, 16);
        push_pixel(0, 0, 0);
        push_pixel(0, 0, 255);
        push_read(0);
        push_read(0);
        push_pixel(63, 63, 255);
        push_pixel(62, 60, 1);
        push_read(255);
        push_pixel(1023, 1023, 7);
        push_pixel(1023, 0, 9);
        push_read(255);
        push_pixel(4, 0, 1);
        push_pixel(5, 1, 2);
        push_pixel(7, 3, 2);
        push_read(1);
        push_read(7);
        push_pixel(10'h2AA, 10'h155, 8'hAA);
        push_pixel(10'h155, 10'h2AA, 8'h55);
        push_pixel(0, 4, 200);
        push_read(16);
        drain_items();

        // zero horizontal pace, then zero vertical pace: pixels vanish
        set_grid(0, 4, 16);
        push_pixel(5, 5, 3);
        push_pixel(0, 0, 1);
        push_read(0);
        push_read(1);
        drain_items();
        set_grid(4, 0, 16);
        push_pixel(5, 5, 3);
        push_read(17);
        drain_items();
        write_reg(CFG_SPARE, 11'h7FF);

        run_phase(4, 4, 16, PHASE_ITEMS);

        // stall the result side long enough that the input backs up
        hold_req = 1'b1;
        repeat (24) push_read($urandom_range(0, NUM_CELLS - 1));
        drain_items();

        run_phase(1, 1, 256, PHASE_ITEMS);
        run_phase(1024, 1024, 256, PHASE_ITEMS);
        run_phase(1, 1, 1, PHASE_ITEMS);
        run_phase(2047, 2047, 511, PHASE_ITEMS);
        run_phase(4, $urandom_range(1, 64), 0, PHASE_ITEMS);
        run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 32),
                  PHASE_ITEMS);
        run_phase($urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(1, 256),
                  PHASE_ITEMS);
        run_phase(3, 5, 20, PHASE_ITEMS);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bads_pkg.sv
hw/rtl/bads_ram.sv
hw/rtl/bads_div.sv
hw/rtl/block_average_downscaler_top.sv
hw/rtl/bads_checker.sv
dv/block_average_downscaler_top_tb.sv
